[rtl/pfle_pkg.sv]
// Package with command codes and shared types for the line and rectangle engine.
package pfle_pkg;

  typedef enum logic [1:0] {
    CMD_LINE  = 2'd0,
    CMD_RECT  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // One pixel request from the stepper to the pixel writer.
  typedef struct packed {
    logic       valid;
    logic [7:0] x;
    logic [7:0] y;
    logic       on;
  } pix_req_t;

endpackage

[rtl/pfle_ram.sv]
// Generic single-port synchronous RAM with registered read.
module pfle_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/pfle_line.sv]
// Bresenham line stepper that emits one pixel request per step.
module pfle_line (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [7:0]      x0_i,
  input  logic [7:0]      y0_i,
  input  logic [7:0]      x1_i,
  input  logic [7:0]      y1_i,
  input  logic            on_i,
  input  logic            adv_i,
  output pfle_pkg::pix_req_t pix_o,
  output logic            busy_o
);

  logic              busy_q, busy_d;
  logic [8:0]        x_q, x_d, y_q, y_d;
  logic [8:0]        x1_q, y1_q;
  logic [8:0]        dx_q, dy_q;
  logic              sx_q, sy_q, on_q;
  logic signed [10:0] err_q, err_d;
  logic signed [11:0] e2;
  logic [8:0]        dxs, dys;

  assign dxs = (x1_i > x0_i) ? {1'b0, x1_i - x0_i} : {1'b0, x0_i - x1_i};
  assign dys = (y1_i > y0_i) ? {1'b0, y1_i - y0_i} : {1'b0, y0_i - y1_i};
  assign e2  = {err_q[10], err_q} <<< 1;

  always_comb begin
    busy_d = busy_q;
    x_d    = x_q;
    y_d    = y_q;
    err_d  = err_q;
    if (busy_q && adv_i) begin
      if (x_q == x1_q && y_q == y1_q) begin
        busy_d = 1'b0;
      end else begin
        if (e2 > -$signed({3'b0, dy_q})) begin
          err_d = err_d - $signed({2'b0, dy_q});
          x_d   = sx_q ? x_q + 9'd1 : x_q - 9'd1;
        end
        if (e2 < $signed({3'b0, dx_q})) begin
          err_d = err_d + $signed({2'b0, dx_q});
          y_d   = sy_q ? y_q + 9'd1 : y_q - 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= {1'b0, x0_i};
      y_q   <= {1'b0, y0_i};
      x1_q  <= {1'b0, x1_i};
      y1_q  <= {1'b0, y1_i};
      dx_q  <= dxs;
      dy_q  <= dys;
      sx_q  <= x0_i < x1_i;
      sy_q  <= y0_i < y1_i;
      on_q  <= on_i;
      err_q <= $signed({2'b0, dxs}) - $signed({2'b0, dys});
    end else begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
    end
  end

  // Coordinates stay in 0..255 along a line, so the low byte is exact.
  assign pix_o.valid = busy_q;
  assign pix_o.x     = x_q[7:0];
  assign pix_o.y     = y_q[7:0];
  assign pix_o.on    = on_q;
  assign busy_o      = busy_q;

endmodule

[rtl/page_framebuffer_line_rect_engine.sv]
// Top level of the page framebuffer line and rectangle engine.
// Commands are taken while busy is low; each produces one strobed result on done_o that
// the receiver cannot stall. Every pixel is a read-modify-write of one framebuffer byte
// through a single-port RAM, in the steps issue, read, wait and write; the write is
// skipped for a pixel off the screen. A filled rectangle of zero width or height touches
// no byte, nor does a read out of range. After reset a clearing pass over every
// framebuffer byte runs with busy high.
module page_framebuffer_line_rect_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command_i,
  input  logic [7:0] x_a_i,
  input  logic [7:0] y_a_i,
  input  logic [7:0] x_b_i,
  input  logic [7:0] y_b_i,
  input  logic       pen_on_i,
  input  logic       fill_rect_i,
  output logic       done_o,
  output logic [7:0] read_byte_o,
  output logic [1:0] done_command_o
);

  localparam int Pages = (SCREEN_HEIGHT + 7) / 8;
  localparam int Depth = Pages * SCREEN_WIDTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = AW + 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SEG, S_LINE, S_RD, S_WAIT, S_WR, S_FILL, S_CLR, S_RDB, S_RDW, S_DONE
  } state_e;

  state_e     state_q;
  logic       busy_q;
  logic [1:0] cmd_q;
  logic [7:0] xa_q, ya_q, xb_q, yb_q, xr_q, ybt_q;
  logic       on_q;
  logic [1:0] seg_q;
  logic [7:0] i_q, j_q;
  logic [CW-1:0] cnt_q;
  logic [7:0] px_q, py_q;
  logic       pon_q, from_fill_q;
  logic       done_q;
  logic [7:0] rb_q;
  logic [1:0] dc_q;

  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata;

  logic       ln_start, ln_adv, ln_busy;
  logic [7:0] l_x0, l_y0, l_x1, l_y1;
  pfle_pkg::pix_req_t ln_pix;

  logic       on_screen;
  logic [CW+8:0] pix_idx;
  logic [7:0] mask;

  assign on_screen = ({1'b0, px_q} < 9'(SCREEN_WIDTH)) && ({1'b0, py_q} < 9'(SCREEN_HEIGHT));
  assign pix_idx   = (CW+9)'(py_q[7:3]) * (CW+9)'(SCREEN_WIDTH) + (CW+9)'(px_q);
  assign mask      = 8'd1 << py_q[2:0];

  always_comb begin
    we    = 1'b0;
    addr  = pix_idx[AW-1:0];
    wdata = pon_q ? (rdata | mask) : (rdata & ~mask);
    case (state_q)
      S_INIT, S_CLR: begin
        we    = 1'b1;
        addr  = cnt_q[AW-1:0];
        wdata = 8'd0;
      end
      S_WR: we = on_screen;
      S_RDB: addr = cnt_q[AW-1:0];
      default: ;
    endcase
  end

  pfle_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // Outline segments: top, right, bottom, left.
  always_comb begin
    case (seg_q)
      2'd0: begin l_x0 = xa_q; l_y0 = ya_q;  l_x1 = xr_q; l_y1 = ya_q;  end
      2'd1: begin l_x0 = xr_q; l_y0 = ya_q;  l_x1 = xr_q; l_y1 = ybt_q; end
      2'd2: begin l_x0 = xr_q; l_y0 = ybt_q; l_x1 = xa_q; l_y1 = ybt_q; end
      default: begin l_x0 = xa_q; l_y0 = ybt_q; l_x1 = xa_q; l_y1 = ya_q; end
    endcase
    if (cmd_q == pfle_pkg::CMD_LINE) begin
      l_x0 = xa_q; l_y0 = ya_q; l_x1 = xb_q; l_y1 = yb_q;
    end
  end

  assign ln_start = (state_q == S_SEG);
  assign ln_adv   = (state_q == S_LINE) && ln_busy;

  pfle_line u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ln_start),
    .x0_i   (l_x0),
    .y0_i   (l_y0),
    .x1_i   (l_x1),
    .y1_i   (l_y1),
    .on_i   (on_q),
    .adv_i  (ln_adv),
    .pix_o  (ln_pix),
    .busy_o (ln_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      seg_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_INIT, S_CLR: begin
          if (cnt_q == CW'(Depth - 1)) begin
            state_q <= (state_q == S_INIT) ? S_IDLE : S_DONE;
            busy_q  <= (state_q != S_INIT);
          end
          cnt_q <= cnt_q + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            busy_q <= 1'b1;
            cmd_q  <= command_i;
            xa_q   <= x_a_i;
            ya_q   <= y_a_i;
            xb_q   <= x_b_i;
            yb_q   <= y_b_i;
            on_q   <= pen_on_i;
            xr_q   <= x_a_i + x_b_i - 8'd1;
            ybt_q  <= y_a_i + y_b_i - 8'd1;
            seg_q  <= '0;
            i_q    <= '0;
            j_q    <= '0;
            cnt_q  <= '0;
            rb_q   <= '0;
            case (pfle_pkg::cmd_e'(command_i))
              pfle_pkg::CMD_LINE:  state_q <= S_SEG;
              pfle_pkg::CMD_RECT:
                state_q <= !fill_rect_i ? S_SEG :
                           (x_b_i == 8'd0 || y_b_i == 8'd0) ? S_DONE : S_FILL;
              pfle_pkg::CMD_CLEAR: state_q <= S_CLR;
              default: begin
                cnt_q <= CW'((CW+9)'(y_a_i) * (CW+9)'(SCREEN_WIDTH) + (CW+9)'(x_a_i));
                state_q <= ({1'b0, x_a_i} < 9'(SCREEN_WIDTH) && {1'b0, y_a_i} < 9'(Pages))
                           ? S_RDB : S_DONE;
              end
            endcase
          end
        end
        S_SEG: state_q <= S_LINE;
        S_LINE: begin
          if (ln_busy) begin
            px_q        <= ln_pix.x;
            py_q        <= ln_pix.y;
            pon_q       <= ln_pix.on;
            from_fill_q <= 1'b0;
            state_q     <= S_RD;
          end else if (cmd_q == pfle_pkg::CMD_RECT && seg_q != 2'd3) begin
            seg_q   <= seg_q + 2'd1;
            state_q <= S_SEG;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_FILL: begin
          px_q        <= xa_q + j_q;
          py_q        <= ya_q + i_q;
          pon_q       <= on_q;
          from_fill_q <= 1'b1;
          state_q     <= S_RD;
          if (j_q == xb_q - 8'd1) begin
            j_q <= '0;
            i_q <= i_q + 8'd1;
          end else begin
            j_q <= j_q + 8'd1;
          end
        end
        S_RD:   state_q <= S_WAIT;
        S_WAIT: state_q <= S_WR;
        S_WR: begin
          if (!from_fill_q) state_q <= S_LINE;
          else if (i_q == yb_q) state_q <= S_DONE;
          else state_q <= S_FILL;
        end
        S_RDB: state_q <= S_RDW;
        S_RDW: begin
          rb_q    <= rdata;
          state_q <= S_DONE;
        end
        S_DONE: begin
          done_q  <= 1'b1;
          dc_q    <= cmd_q;
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The byte for a read is captured in S_RDW and presented with the result strobe.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE) begin
      read_byte_o <= (cmd_q == pfle_pkg::CMD_READ) ? rb_q : 8'd0;
    end
  end

  assign busy           = busy_q;
  assign done_o         = done_q;
  assign done_command_o = dc_q;

endmodule

[rtl/pfle_checker.sv]
// Port-level checker for the engine, bound to the top level.
module pfle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] done_command_o,
  input logic [7:0] read_byte_o
);

  a_done_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy high with result strobe");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after request");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && done_command_o != pfle_pkg::CMD_READ) |-> read_byte_o == 8'd0)
    else $error("nonzero byte on non-read result");

endmodule

bind page_framebuffer_line_rect_engine pfle_checker u_pfle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .done_command_o(done_command_o),
  .read_byte_o   (read_byte_o)
);
